### design/assert_macros.svh
// Assertion macros shared by the nearest point search RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

### design/npss_pkg.sv
// Package: command codes, field widths and controller/datapath interface types.
`timescale 1ns / 1ps

package npss_pkg;

	localparam int COORD_W  = 24;
	localparam int RADIUS_W = 23;
	localparam int IDX_W    = 6;
	localparam int SKIP_W   = 7;
	localparam int PT_W     = 3 * COORD_W;
	localparam int DIFF_W   = COORD_W + 1;
	localparam int SQ_W     = 2 * COORD_W + 1;
	localparam int SUM_W    = SQ_W + 1;
	localparam int R2_W     = 2 * RADIUS_W;

	typedef enum logic [1:0] {
		CMD_INSERT  = 2'd0,
		CMD_NEAREST = 2'd1,
		CMD_RADIUS  = 2'd2,
		CMD_CLEAR   = 2'd3
	} cmd_t;

	// controller -> datapath
	typedef struct packed {
		logic             load;
		logic             rd_en;
		logic             rd_tail;
		logic [IDX_W-1:0] rd_addr;
		logic             wr_en;
		logic [IDX_W-1:0] wr_addr;
		logic             ins_emit;
		logic             ins_ok;
		logic             flush;
	} npss_ctl_t;

	// datapath -> controller
	typedef struct packed {
		logic scan_done;
		logic pipe_busy;
	} npss_sts_t;

endpackage

### design/nearest_point_search_3d_top.sv
// Top level: 3D point table with nearest point and radius search.
`timescale 1ns / 1ps

//  channel  | signals                                           | handshake
//  ---------+---------------------------------------------------+---------------------------
//  command  | command, pos_x/y/z, skip_first, skip_second       | start & !busy
//  result   | point_index, found, last                          | result_valid, 1-cycle strobe
//  config   | cfg_data (neighbor radius, Q15.8 unsigned)        | cfg_valid & cfg_ready
//
//  Insert: accept plus the table write; the result strobes the cycle after.
//  Nearest / radius: one table entry is read per
//  cycle from the point memory and goes through a 4-stage squared
//  distance pipe (read, diff, square, sum) before the compare stage.
//  Empty table queries go straight to the flush; clear resets the count and gives no result.
//  Reset: table empty, radius 0; memory contents are not cleared.
//  The receiver cannot stall: each result is valid for exactly one cycle.

module nearest_point_search_3d_top #(
	parameter int MAX_POINTS = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// command channel
	input  logic                                start,
	output logic                                busy,
	input  logic [1:0]                          command,
	input  logic signed [npss_pkg::COORD_W-1:0] pos_x,
	input  logic signed [npss_pkg::COORD_W-1:0] pos_y,
	input  logic signed [npss_pkg::COORD_W-1:0] pos_z,
	input  logic [npss_pkg::SKIP_W-1:0]         skip_first,
	input  logic [npss_pkg::SKIP_W-1:0]         skip_second,
	// result channel
	output logic                                result_valid,
	output logic [npss_pkg::IDX_W-1:0]          point_index,
	output logic                                found,
	output logic                                last,
	// configuration channel
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [npss_pkg::RADIUS_W-1:0]       cfg_data
);

	npss_pkg::npss_ctl_t ctl;
	npss_pkg::npss_sts_t sts;

	// radius register takes a write in any cycle
	assign cfg_ready = 1'b1;

	// sequencing: decode, point count, scan addresses, final flush
	npss_ctrl #(
		.MAX_POINTS (MAX_POINTS)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.command (command),
		.sts     (sts),
		.ctl     (ctl),
		.busy    (busy)
	);

	// storage, distance pipe, compare and result register
	npss_dp #(
		.MAX_POINTS (MAX_POINTS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.command      (command),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.pos_z        (pos_z),
		.skip_first   (skip_first),
		.skip_second  (skip_second),
		.cfg_valid    (cfg_valid),
		.cfg_data     (cfg_data),
		.ctl          (ctl),
		.sts          (sts),
		.result_valid (result_valid),
		.point_index  (point_index),
		.found        (found),
		.last         (last)
	);

endmodule

### design/npss_ctrl.sv
// Controller: command decode, point count, scan address sequencing.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module npss_ctrl #(
	parameter int MAX_POINTS = 64
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [1:0]              command,
	input  npss_pkg::npss_sts_t     sts,
	output npss_pkg::npss_ctl_t     ctl,
	output logic                    busy
);

	localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CW = $clog2(MAX_POINTS + 1);

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_INSERT = 5'b00010,
		ST_SCAN   = 5'b00100,
		ST_DRAIN  = 5'b01000,
		ST_FLUSH  = 5'b10000
	} state_t;

	state_t         state_q, state_d;
	logic [CW-1:0]  count_q, count_d;
	logic [AW-1:0]  addr_q, addr_d;
	logic           tail;
	logic           full;

	assign tail = (CW'(addr_q) + CW'(1)) == count_q;
	assign full = count_q == CW'(MAX_POINTS);
	assign busy = state_q != ST_IDLE;

	always_comb begin
		state_d     = state_q;
		count_d     = count_q;
		addr_d      = addr_q;
		ctl         = '0;
		ctl.rd_addr = npss_pkg::IDX_W'(addr_q);
		ctl.wr_addr = npss_pkg::IDX_W'(count_q[AW-1:0]);
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					ctl.load = 1'b1;
					addr_d   = '0;
					unique case (npss_pkg::cmd_t'(command)) inside
						npss_pkg::CMD_INSERT: state_d = ST_INSERT;
						npss_pkg::CMD_NEAREST, npss_pkg::CMD_RADIUS: begin
							state_d = (count_q == '0) ? ST_FLUSH : ST_SCAN;
						end
						npss_pkg::CMD_CLEAR: count_d = '0;
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_INSERT: begin
				ctl.ins_emit = 1'b1;
				ctl.ins_ok   = !full;
				ctl.wr_en    = !full;
				if (!full) begin
					count_d = count_q + CW'(1);
				end
				state_d = ST_IDLE;
			end
			ST_SCAN: begin
				ctl.rd_en   = 1'b1;
				ctl.rd_tail = tail;
				addr_d      = addr_q + AW'(1);
				if (tail) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (sts.scan_done) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				ctl.flush = 1'b1;
				state_d   = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			addr_q  <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			addr_q  <= addr_d;
		end
	end

	`ASSERT_NEVER(a_count_range, clk, arst_n, count_q > CW'(MAX_POINTS), "point count past capacity")
	`ASSERT_CLK(a_idle_after_result, clk, arst_n, $fell(busy) |-> $past(ctl.flush || ctl.ins_emit), "busy dropped without a final result")
	`ASSERT_NEVER(a_flush_pipe_empty, clk, arst_n, ctl.flush && sts.pipe_busy, "flush while scan still in flight")

endmodule

### design/npss_dp.sv
// Datapath: point memory, squared distance pipeline, nearest/radius accumulator.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module npss_dp #(
	parameter int MAX_POINTS = 64
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic [1:0]                             command,
	input  logic signed [npss_pkg::COORD_W-1:0]    pos_x,
	input  logic signed [npss_pkg::COORD_W-1:0]    pos_y,
	input  logic signed [npss_pkg::COORD_W-1:0]    pos_z,
	input  logic [npss_pkg::SKIP_W-1:0]            skip_first,
	input  logic [npss_pkg::SKIP_W-1:0]            skip_second,
	input  logic                                   cfg_valid,
	input  logic [npss_pkg::RADIUS_W-1:0]          cfg_data,
	input  npss_pkg::npss_ctl_t                    ctl,
	output npss_pkg::npss_sts_t                    sts,
	output logic                                   result_valid,
	output logic [npss_pkg::IDX_W-1:0]             point_index,
	output logic                                   found,
	output logic                                   last
);

	localparam int AW     = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CW     = npss_pkg::COORD_W;
	localparam int DIFF_W = npss_pkg::DIFF_W;
	localparam int SQ_W   = npss_pkg::SQ_W;
	localparam int SUM_W  = npss_pkg::SUM_W;
	localparam int R2_W   = npss_pkg::R2_W;

	// point memory, {x, y, z}
	logic [npss_pkg::PT_W-1:0] mem_q [MAX_POINTS];

	// latched query
	logic signed [CW-1:0]           qx_q, qy_q, qz_q;
	logic [npss_pkg::SKIP_W-1:0]    skip1_q, skip2_q;
	logic                           radius_mode_q;
	logic [R2_W-1:0]                r2_q;

	// scan pipeline
	logic                           vld_s1, vld_s2, vld_s3, vld_s4;
	logic                           tail_s1, tail_s2, tail_s3, tail_s4;
	logic [AW-1:0]                  idx_s1, idx_s2, idx_s3, idx_s4;
	logic [npss_pkg::PT_W-1:0]      data_s1;
	logic signed [DIFF_W-1:0]       dx_s2, dy_s2, dz_s2;
	logic [SQ_W-1:0]                sqx_s3, sqy_s3, sqz_s3;
	logic [SUM_W-1:0]               sum_s4;

	// accumulator and result register
	logic                           have_q;
	logic [AW-1:0]                  best_idx_q;
	logic [SUM_W-1:0]               best_d_q;
	logic                           scan_done_q;
	logic                           res_valid_q;
	logic [npss_pkg::IDX_W-1:0]     res_idx_q;
	logic                           res_found_q;
	logic                           res_last_q;

	logic signed [CW-1:0]           px, py, pz;
	logic signed [2*DIFF_W-1:0]     prod_x, prod_y, prod_z;
	logic                           closer;
	logic                           hit;

	assign px = data_s1[3*CW-1:2*CW];
	assign py = data_s1[2*CW-1:CW];
	assign pz = data_s1[CW-1:0];

	assign prod_x = dx_s2 * dx_s2;
	assign prod_y = dy_s2 * dy_s2;
	assign prod_z = dz_s2 * dz_s2;

	assign closer = !have_q || (sum_s4 < best_d_q);
	assign hit    = (sum_s4 <= SUM_W'(r2_q))
		&& (npss_pkg::SKIP_W'(idx_s4) != skip1_q)
		&& (npss_pkg::SKIP_W'(idx_s4) != skip2_q);

	// memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem_q[ctl.wr_addr[AW-1:0]] <= {qx_q, qy_q, qz_q};
		end
		data_s1 <= mem_q[ctl.rd_addr[AW-1:0]];
	end

	// query latch
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			qx_q          <= pos_x;
			qy_q          <= pos_y;
			qz_q          <= pos_z;
			skip1_q       <= skip_first;
			skip2_q       <= skip_second;
			radius_mode_q <= npss_pkg::cmd_t'(command) == npss_pkg::CMD_RADIUS;
		end
	end

	// radius register holds the squared radius
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r2_q <= '0;
		end else if (cfg_valid) begin
			r2_q <= R2_W'(cfg_data) * R2_W'(cfg_data);
		end
	end

	// pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			vld_s3      <= 1'b0;
			vld_s4      <= 1'b0;
			scan_done_q <= 1'b0;
		end else begin
			vld_s1      <= ctl.rd_en;
			vld_s2      <= vld_s1;
			vld_s3      <= vld_s2;
			vld_s4      <= vld_s3;
			scan_done_q <= vld_s4 && tail_s4;
		end
	end

	// pipeline payload
	always_ff @(posedge clk) begin
		tail_s1 <= ctl.rd_tail;
		idx_s1  <= ctl.rd_addr[AW-1:0];
		tail_s2 <= tail_s1;
		idx_s2  <= idx_s1;
		tail_s3 <= tail_s2;
		idx_s3  <= idx_s2;
		tail_s4 <= tail_s3;
		idx_s4  <= idx_s3;
		dx_s2   <= DIFF_W'(px) - DIFF_W'(qx_q);
		dy_s2   <= DIFF_W'(py) - DIFF_W'(qy_q);
		dz_s2   <= DIFF_W'(pz) - DIFF_W'(qz_q);
		sqx_s3  <= prod_x[SQ_W-1:0];
		sqy_s3  <= prod_y[SQ_W-1:0];
		sqz_s3  <= prod_z[SQ_W-1:0];
		sum_s4  <= SUM_W'(sqx_s3) + SUM_W'(sqy_s3) + SUM_W'(sqz_s3);
	end

	// accumulator; in radius mode best_idx_q is the pending match
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q <= 1'b0;
		end else if (ctl.load) begin
			have_q <= 1'b0;
		end else if (vld_s4 && (radius_mode_q ? hit : closer)) begin
			have_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s4 && (radius_mode_q ? hit : closer)) begin
			best_idx_q <= idx_s4;
			best_d_q   <= sum_s4;
		end
	end

	// result register: one strobe per result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= ctl.ins_emit || ctl.flush
				|| (vld_s4 && radius_mode_q && hit && have_q);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.ins_emit) begin
			res_idx_q   <= ctl.ins_ok ? ctl.wr_addr : '0;
			res_found_q <= ctl.ins_ok;
			res_last_q  <= 1'b1;
		end else if (ctl.flush) begin
			res_idx_q   <= have_q ? npss_pkg::IDX_W'(best_idx_q) : '0;
			res_found_q <= have_q;
			res_last_q  <= 1'b1;
		end else begin
			// a newer match pushes out the pending one, not last
			res_idx_q   <= npss_pkg::IDX_W'(best_idx_q);
			res_found_q <= 1'b1;
			res_last_q  <= 1'b0;
		end
	end

	assign sts.scan_done = scan_done_q;
	assign sts.pipe_busy = vld_s1 || vld_s2 || vld_s3 || vld_s4;

	assign result_valid = res_valid_q;
	assign point_index  = res_idx_q;
	assign found        = res_found_q;
	assign last         = res_last_q;

	`ASSERT_CLK(a_miss_is_last, clk, arst_n, (res_valid_q && !res_found_q) |-> res_last_q, "result without index not marked last")
	`ASSERT_CLK(a_done_pipe_empty, clk, arst_n, scan_done_q |-> !(vld_s1 || vld_s2 || vld_s3 || vld_s4), "scan end seen with entries still in flight")
	`ASSERT_CLK(a_open_only_radius, clk, arst_n, (res_valid_q && !res_last_q) |-> radius_mode_q, "non-final result outside radius query")

endmodule
